[hdl/fpbc_pkg.sv]
// ----------------------------------------------------------------------------
// fpbc_pkg
// Shared types and constants for frustum plane extraction and box culling.
// ----------------------------------------------------------------------------
package fpbc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int MATRIX_SIZE = 16;
    localparam int NRM_FRAC    = 30;   // Q2.30 normal fraction bits
    localparam int DIV_NUM_W   = 33;   // divider numerator width

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_BOX     = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EX_COMP,
        S_EX_MAG,
        S_EX_NORM,
        S_EX_SQ,
        S_EX_SQRTGO,
        S_EX_SQRTW,
        S_EX_DIVGO,
        S_EX_DIVW,
        S_EX_NEXT,
        S_BX_MUL,
        S_BX_CHECK,
        S_DONE
    } t_state;

    // Matrix row combined with row 3 for each plane:
    // left/right use row 0, near/far row 2, bottom/top row 1.
    function automatic logic [1:0] row_sel(input logic [2:0] plane);
        logic [1:0] r;
        unique case (plane)
            3'd0, 3'd1: r = 2'd0;
            3'd2, 3'd3: r = 2'd2;
            default:    r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

[hdl/fpbc_if.sv]
// ----------------------------------------------------------------------------
// fpbc channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface fpbc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [3:0]        matrix_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source (
        output valid, opcode, matrix_index, matrix_value,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, matrix_index, matrix_value,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface fpbc_out_if;
    logic       valid;
    logic       ready;
    logic       culled;
    logic [2:0] planes_passed;
    logic [2:0] degenerate_planes;

    modport source (
        output valid, culled, planes_passed, degenerate_planes,
        input  ready
    );
    modport sink (
        input  valid, culled, planes_passed, degenerate_planes,
        output ready
    );
endinterface

[hdl/fpbc_mul.sv]
// ----------------------------------------------------------------------------
// fpbc_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fpbc_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    // Register every product
    always_ff @(posedge i_clk) begin
        r_p <= 66'(i_a) * 66'(i_b);
    end

    assign o_p = r_p;
endmodule

[hdl/fpbc_sqrt.sv]
// ----------------------------------------------------------------------------
// fpbc_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fpbc_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    import fpbc_pkg::*;

    localparam logic [62:0] BIT_TOP = {1'b1, 62'b0};

    logic        r_busy;
    logic        r_done;
    logic [62:0] r_v;
    logic [62:0] r_res;
    logic [62:0] r_bit;
    logic [62:0] trial;

    assign trial = r_res + r_bit;

    // Control: run until the trial bit has passed bit zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: one subtract and compare per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= {1'b0, i_value};
            r_res <= '0;
            r_bit <= BIT_TOP;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

[hdl/fpbc_div.sv]
// ----------------------------------------------------------------------------
// fpbc_div
// Restoring serial divider: floor(num * 2^zeros / den), saturation flagged.
// ----------------------------------------------------------------------------
module fpbc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [5:0]  i_zeros,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic        o_ovf
);
    import fpbc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [32:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic [31:0] r_q;
    logic        r_sticky;
    logic [32:0] rem2;
    logic        take;

    assign rem2 = {r_rem, r_num[32]};
    assign take = rem2 >= {1'b0, r_den};

    // Control: one numerator bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 7'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DIV_NUM_W) + 7'(i_zeros);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: shift in a bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num    <= i_num;
            r_den    <= i_den;
            r_rem    <= '0;
            r_q      <= '0;
            r_sticky <= 1'b0;
        end else if (r_busy) begin
            r_num    <= r_num << 1;
            r_rem    <= take ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
            r_sticky <= r_sticky | r_q[31];
            r_q      <= {r_q[30:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_ovf  = r_sticky | r_q[31];
endmodule

[hdl/frustum_plane_extract_and_box_cull.sv]
// ----------------------------------------------------------------------------
// frustum_plane_extract_and_box_cull
// Extracts six normalized frustum planes from a stored 4x4 matrix and culls
// axis-aligned boxes against them, using one shared multiplier, a serial
// square root and a serial divider under a small sequencer.
//
//  Port    Dir  Content
//  i_in    in   opcode, matrix_index/value, box_min_xyz, box_max_xyz
//  o_out   out  culled, planes_passed, degenerate_planes
//
//  Matrix write and no-op: from idle straight to the done state.
//  Box test: per plane, the distance plus three products of the shared
//  multiplier passes if positive. Extraction: per plane, components,
//  magnitudes, shift normalization, squares, square root, four divisions.
//  i_in.ready is high only in the idle state; a held result does not block
//  the next transfer in. Reset is synchronous, active low; plane storage
//  resets to zero, the matrix is not reset.
// ----------------------------------------------------------------------------
module frustum_plane_extract_and_box_cull (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpbc_in_if.sink     i_in,
    fpbc_out_if.source  o_out
);
    import fpbc_pkg::*;

    t_state              r_state, n_state;
    t_opcode             r_op;
    logic [2:0]          r_plane;
    logic [2:0]          r_cnt;
    logic signed [31:0]  r_mat [MATRIX_SIZE];
    logic signed [31:0]  r_nrm [3*NUM_PLANES];
    logic signed [31:0]  r_dst [NUM_PLANES];
    logic signed [32:0]  r_comp [4];
    logic [32:0]         r_um [3];
    logic [32:0]         r_top;
    logic [5:0]          r_exp;
    logic signed [65:0]  r_acc;
    logic [31:0]         r_root;
    logic [2:0]          r_deg;
    logic [2:0]          r_pass;
    logic signed [31:0]  r_lo [3];
    logic signed [31:0]  r_hi [3];
    logic                r_out_valid;
    logic                r_out_culled;
    logic [2:0]          r_out_passed;
    logic [2:0]          r_out_deg;

    logic                in_fire;
    logic                out_load;
    logic [1:0]          rsel;
    logic signed [32:0]  comp_c [4];
    logic [32:0]         um_c [3];
    logic [32:0]         top_c;
    logic [1:0]          a_idx;
    logic [4:0]          n_idx;
    logic signed [31:0]  nrm_sel;
    logic signed [31:0]  coord;
    logic [32:0]         d_mag;
    logic [31:0]         q_signed;
    logic [31:0]         d_sat;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;
    logic                sq_start, sq_done;
    logic [31:0]         sq_root;
    logic                dv_start, dv_done, dv_ovf;
    logic [32:0]         dv_num;
    logic [5:0]          dv_zeros;
    logic [31:0]         dv_q;

    fpbc_mul u_mul (
        .i_clk (i_clk), .i_a (mul_a), .i_b (mul_b), .o_p (mul_p)
    );

    fpbc_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (sq_start),
        .i_value (r_acc[61:0]), .o_done (sq_done), .o_root (sq_root)
    );

    fpbc_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (dv_start),
        .i_num (dv_num), .i_zeros (dv_zeros), .i_den (r_root),
        .o_done (dv_done), .o_quot (dv_q), .o_ovf (dv_ovf)
    );

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // Raw plane components: row 3 plus or minus the selected row
    assign rsel = row_sel(r_plane);
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            comp_c[j] = r_plane[0]
                ? 33'(r_mat[{2'(j), 2'd3}]) - 33'(r_mat[{2'(j), rsel}])
                : 33'(r_mat[{2'(j), 2'd3}]) + 33'(r_mat[{2'(j), rsel}]);
        end
    end

    // Magnitudes of the normal and their maximum
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            um_c[j] = r_comp[j][32] ? 33'(-r_comp[j]) : 33'(r_comp[j]);
        end
        top_c = um_c[0];
        if (um_c[1] > top_c) top_c = um_c[1];
        if (um_c[2] > top_c) top_c = um_c[2];
    end

    // Axis and stored-normal select for the current step
    assign a_idx   = (r_cnt == 3'd3) ? 2'd0 : r_cnt[1:0];
    assign n_idx   = 5'(5'(r_plane) * 5'd3) + 5'(a_idx);
    assign nrm_sel = r_nrm[n_idx];
    // Pick the box extent that maximizes the product on this axis
    always_comb begin
        if (nrm_sel[31]) begin
            coord = (r_lo[a_idx] < r_hi[a_idx]) ? r_lo[a_idx] : r_hi[a_idx];
        end else begin
            coord = (r_lo[a_idx] > r_hi[a_idx]) ? r_lo[a_idx] : r_hi[a_idx];
        end
    end

    assign d_mag    = r_comp[3][32] ? 33'(-r_comp[3]) : 33'(r_comp[3]);
    assign q_signed = r_comp[a_idx][32] ? 32'(-dv_q) : dv_q;
    assign d_sat    = dv_ovf ? (r_comp[3][32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                             : (r_comp[3][32] ? 32'(-dv_q) : dv_q);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (t_opcode'(i_in.opcode))
                        OP_EXTRACT: n_state = S_EX_COMP;
                        OP_BOX:     n_state = S_BX_MUL;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_EX_COMP: n_state = S_EX_MAG;
            S_EX_MAG:  n_state = S_EX_NORM;
            S_EX_NORM: begin
                if (r_top == '0) begin
                    n_state = S_EX_NEXT;
                end else if (r_top[32:30] == '0 && r_top[29]) begin
                    n_state = S_EX_SQ;
                end
            end
            S_EX_SQ:     if (r_cnt == 3'd3) n_state = S_EX_SQRTGO;
            S_EX_SQRTGO: n_state = S_EX_SQRTW;
            S_EX_SQRTW:  if (sq_done) n_state = S_EX_DIVGO;
            S_EX_DIVGO:  n_state = S_EX_DIVW;
            S_EX_DIVW: begin
                if (dv_done) n_state = (r_cnt == 3'd3) ? S_EX_NEXT : S_EX_DIVGO;
            end
            S_EX_NEXT: begin
                n_state = (r_plane == 3'(NUM_PLANES - 1)) ? S_DONE : S_EX_COMP;
            end
            S_BX_MUL:   if (r_cnt == 3'd3) n_state = S_BX_CHECK;
            S_BX_CHECK: begin
                n_state = (r_plane == 3'(NUM_PLANES - 1)) ? S_DONE : S_BX_MUL;
            end
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: unit operands and start strobes
    always_comb begin
        i_in.ready = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        dv_num     = '0;
        dv_zeros   = '0;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_EX_SQ: begin
                mul_a = $signed(r_um[a_idx]);
                mul_b = $signed(r_um[a_idx]);
            end
            S_EX_SQRTGO: sq_start = 1'b1;
            S_EX_DIVGO: begin
                dv_start = 1'b1;
                if (r_cnt == 3'd3) begin
                    dv_num   = d_mag;
                    dv_zeros = r_exp;
                end else begin
                    dv_num   = r_um[a_idx];
                    dv_zeros = 6'(NRM_FRAC);
                end
            end
            S_BX_MUL: begin
                mul_a = 33'(coord);
                mul_b = 33'(nrm_sel);
            end
            default: ;
        endcase
    end

    // State register and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plane <= '0;
            r_cnt   <= '0;
            r_deg   <= '0;
            r_pass  <= '0;
            r_op    <= OP_NOP;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= t_opcode'(i_in.opcode);
                        r_plane <= '0;
                        r_cnt   <= '0;
                        r_deg   <= '0;
                        r_pass  <= '0;
                    end
                end
                S_EX_NORM: begin
                    if (r_top == '0) r_deg <= r_deg + 3'd1;
                    r_cnt <= '0;
                end
                S_EX_SQ:    r_cnt <= (r_cnt == 3'd3) ? 3'd0 : r_cnt + 3'd1;
                S_EX_DIVW:  if (dv_done) r_cnt <= r_cnt + 3'd1;
                S_EX_NEXT:  r_plane <= r_plane + 3'd1;
                S_BX_MUL:   r_cnt <= (r_cnt == 3'd3) ? 3'd0 : r_cnt + 3'd1;
                S_BX_CHECK: begin
                    if (!r_acc[65] && r_acc != '0) r_pass <= r_pass + 3'd1;
                    r_plane <= r_plane + 3'd1;
                end
                default: ;
            endcase
        end
    end

    // Matrix store: written by transfers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire && t_opcode'(i_in.opcode) == OP_WRITE) begin
            r_mat[i_in.matrix_index] <= i_in.matrix_value;
        end
    end

    // Plane storage: cleared by reset, written by extraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3*NUM_PLANES; i++) r_nrm[i] <= '0;
            for (int i = 0; i < NUM_PLANES; i++) r_dst[i] <= '0;
        end else if (r_state == S_EX_NORM && r_top == '0) begin
            for (int j = 0; j < 3; j++) r_nrm[5'(5'(r_plane) * 5'd3) + 5'(j)] <= '0;
            r_dst[r_plane] <= '0;
        end else if (r_state == S_EX_DIVW && dv_done) begin
            if (r_cnt == 3'd3) begin
                r_dst[r_plane] <= d_sat;
            end else begin
                r_nrm[n_idx] <= q_signed;
            end
        end
    end

    // Datapath registers: box bounds, components, shift normalization, accumulator, root
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_lo[0] <= i_in.box_min_x;
                    r_lo[1] <= i_in.box_min_y;
                    r_lo[2] <= i_in.box_min_z;
                    r_hi[0] <= i_in.box_max_x;
                    r_hi[1] <= i_in.box_max_y;
                    r_hi[2] <= i_in.box_max_z;
                end
            end
            S_EX_COMP: begin
                for (int j = 0; j < 4; j++) r_comp[j] <= comp_c[j];
            end
            S_EX_MAG: begin
                for (int j = 0; j < 3; j++) r_um[j] <= um_c[j];
                r_top <= top_c;
                r_exp <= 6'd16;
            end
            S_EX_NORM: begin
                if (r_top[32:30] != '0) begin
                    for (int j = 0; j < 3; j++) r_um[j] <= r_um[j] >> 1;
                    r_top <= r_top >> 1;
                    r_exp <= r_exp - 6'd1;
                end else if (!r_top[29] && r_top != '0) begin
                    for (int j = 0; j < 3; j++) r_um[j] <= r_um[j] << 1;
                    r_top <= r_top << 1;
                    r_exp <= r_exp + 6'd1;
                end
            end
            S_EX_SQ: begin
                r_acc <= (r_cnt == 3'd0) ? 66'sd0 : r_acc + mul_p;
            end
            S_EX_SQRTW: if (sq_done) r_root <= sq_root;
            S_BX_MUL: begin
                if (r_cnt == 3'd0) begin
                    r_acc <= {{4{r_dst[r_plane][31]}}, r_dst[r_plane], 30'b0};
                end else begin
                    r_acc <= r_acc + mul_p;
                end
            end
            default: ;
        endcase
    end

    // Result register: hold until the transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_culled <= (r_op == OP_BOX) && (r_pass != 3'(NUM_PLANES));
            r_out_passed <= r_pass;
            r_out_deg    <= r_deg;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.culled            = r_out_culled;
    assign o_out.planes_passed     = r_out_passed;
    assign o_out.degenerate_planes = r_out_deg;

    // Checks
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= 3'(NUM_PLANES))
        else $error("pass count out of range");

    a_box_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && t_opcode'(i_in.opcode) == OP_BOX) |=> (r_state == S_BX_MUL))
        else $error("box test did not start");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX_DIVGO) |-> (!r_root[31] && (r_root[30] || r_root[29])))
        else $error("root outside normalized range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule
